// ===== rtl/lmss_pkg.sv =====
package lmss_pkg;

	// fixed field widths
	localparam int DATA_W     = 16;
	localparam int ROW_FLD_W  = 4;
	localparam int WORD_FLD_W = 5;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int RATE_W     = 8;
	localparam int STATIC_W   = 5;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SCROLL_ON    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SCROLL_RATE  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_STATIC_WORDS = 2'd2;

	// scroll rate codes that swap meaning
	localparam logic [RATE_W-1:0] RATE_CODE_FAST = 8'd2;
	localparam logic [RATE_W-1:0] RATE_CODE_HALF = 8'd1;

	// input function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_SCAN  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_LD,
		ST_ROT_RD0,
		ST_ROT_FIRST,
		ST_ROT_RD,
		ST_ROT_WR,
		ST_ROT_LAST
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic start;
		logic in_wr;
		logic clr_wr;
		logic scan_rd;
		logic scan_ld;
		logic rot_rd;
		logic rot_first;
		logic rot_wr;
		logic rot_last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic shown_last;
		logic word_end;
		logic row_end;
		logic out_free;
		logic rotate_due;
	} sts_t;

endpackage

// ===== rtl/lmss_if.sv =====
interface lmss_in_if import lmss_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [ROW_FLD_W-1:0]  wr_row;
	logic [WORD_FLD_W-1:0] wr_word;
	logic [DATA_W-1:0]     wr_data;

	modport source (output valid, func, wr_row, wr_word, wr_data, input ready);
	modport sink (input valid, func, wr_row, wr_word, wr_data, output ready);
endinterface

interface lmss_out_if import lmss_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] row_drive;
	logic [DATA_W-1:0] col_data;
	logic              last_word;

	modport source (output valid, row_drive, col_data, last_word, input ready);
	modport sink (input valid, row_drive, col_data, last_word, output ready);
endinterface

interface lmss_cfg_if import lmss_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/led_matrix_scan_scroll.sv =====
// LED matrix row scanner with horizontal scroll. After reset the frame store is cleared
// one word a cycle, and no item is taken until that pass ends; configuration writes are
// taken at any time. A write item to an in-range row and word goes straight into the
// frame store. A tick item reads the shown words of its row one at a time over the single
// frame store port, each read followed by a load into the output register. A tick that
// ends a frame on which the scroll period is reached, while scroll is on and static_words
// is below ROW_WORDS, then rotates every row through the same port, from word static_words
// to the row end. Result words leave through an output register, so a stalled output
// holds the scan but never loses a word.
module led_matrix_scan_scroll import lmss_pkg::*; #(
	parameter int ROWS        = 16,
	parameter int ROW_WORDS   = 32,
	parameter int SHOWN_WORDS = 27
) (
	input logic       clk,
	input logic       arst_n,
	lmss_in_if.sink   din,
	lmss_out_if.source dout,
	lmss_cfg_if.sink  cfg
);

	cmd_t cmd;
	sts_t sts;

	// configuration registers always accept
	assign cfg.ready = 1'b1;

	lmss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_func  (din.func),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lmss_dp #(
		.ROWS        (ROWS),
		.ROW_WORDS   (ROW_WORDS),
		.SHOWN_WORDS (SHOWN_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg.valid),
		.cfg_addr  (cfg.addr),
		.cfg_data  (cfg.data),
		.wr_row    (din.wr_row),
		.wr_word   (din.wr_word),
		.wr_data   (din.wr_data),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.row_drive (dout.row_drive),
		.col_data  (dout.col_data),
		.last_word (dout.last_word)
	);

endmodule

// ===== rtl/lmss_ctrl.sv =====
module lmss_ctrl import lmss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && in_func == FUNC_SCAN) state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_LD;
			end
			ST_SCAN_LD: begin
				if (sts.out_free) begin
					if (!sts.shown_last) state_d = ST_SCAN_RD;
					else if (sts.rotate_due) state_d = ST_ROT_RD0;
					else state_d = ST_IDLE;
				end
			end
			ST_ROT_RD0: begin
				state_d = ST_ROT_FIRST;
			end
			ST_ROT_FIRST, ST_ROT_WR: begin
				state_d = sts.word_end ? ST_ROT_LAST : ST_ROT_RD;
			end
			ST_ROT_RD: begin
				state_d = ST_ROT_WR;
			end
			ST_ROT_LAST: begin
				state_d = sts.row_end ? ST_IDLE : ST_ROT_RD0;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid && in_func == FUNC_SCAN;
				cmd.in_wr = in_valid && in_func == FUNC_WRITE;
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
			end
			ST_SCAN_LD: begin
				cmd.scan_ld = sts.out_free;
			end
			ST_ROT_RD0, ST_ROT_RD: begin
				cmd.rot_rd = 1'b1;
			end
			ST_ROT_FIRST: begin
				cmd.rot_first = 1'b1;
			end
			ST_ROT_WR: begin
				cmd.rot_wr = 1'b1;
			end
			ST_ROT_LAST: begin
				cmd.rot_last = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/lmss_dp.sv =====
module lmss_dp import lmss_pkg::*; #(
	parameter int ROWS        = 16,
	parameter int ROW_WORDS   = 32,
	parameter int SHOWN_WORDS = 27
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [ROW_FLD_W-1:0]  wr_row,
	input  logic [WORD_FLD_W-1:0] wr_word,
	input  logic [DATA_W-1:0]     wr_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DATA_W-1:0]     row_drive,
	output logic [DATA_W-1:0]     col_data,
	output logic                  last_word
);

	localparam int DEPTH   = ROWS * ROW_WORDS;
	localparam int AW      = $clog2(DEPTH);
	localparam int RBW     = $clog2(ROWS);
	localparam int WBW     = $clog2(ROW_WORDS);
	localparam int SHOWN_N = (SHOWN_WORDS < ROW_WORDS) ? SHOWN_WORDS : ROW_WORDS;

	// configuration registers
	logic                scroll_on_q;
	logic [RATE_W-1:0]   scroll_rate_q;
	logic [STATIC_W-1:0] static_q;

	// sequencing state
	logic [RBW-1:0]    scan_q;
	logic [RATE_W-1:0] cnt_q;
	logic [RBW-1:0]    row_q;
	logic [WBW-1:0]    word_q;
	logic [DATA_W-1:0] prev_q;
	logic              carry_q;

	// frame store
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// output word register
	logic              out_valid_q;
	logic [DATA_W-1:0] row_drive_q;
	logic [DATA_W-1:0] col_data_q;
	logic              last_q;

	logic [RBW-1:0]    scan_row;
	logic [WBW-1:0]    first_word;
	logic              static_fits;
	logic [AW-1:0]     base_addr;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     prev_addr;
	logic [AW-1:0]     scan_addr;
	logic [AW-1:0]     in_addr;
	logic              in_ok;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_wa;
	logic [AW-1:0]     mem_ra;
	logic [DATA_W-1:0] mem_wd;
	logic [RATE_W-1:0] period;
	logic [RATE_W-1:0] cnt_next;
	logic              frame_wrap;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_on_q   <= 1'b0;
			scroll_rate_q <= RATE_W'(2);
			static_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SCROLL_ON:    scroll_on_q   <= cfg_data[0];
				REG_SCROLL_RATE:  scroll_rate_q <= cfg_data[RATE_W-1:0];
				REG_STATIC_WORDS: static_q      <= cfg_data[STATIC_W-1:0];
				default: ;
			endcase
		end
	end

	// scroll period from the speed code
	always_comb begin
		unique case (scroll_rate_q)
			RATE_CODE_FAST: period = RATE_W'(1);
			RATE_CODE_HALF: period = RATE_W'(2);
			default:        period = scroll_rate_q;
		endcase
	end

	assign cnt_next    = cnt_q + RATE_W'(1);
	assign frame_wrap  = scan_q == RBW'(ROWS - 1);
	assign static_fits = int'(static_q) < ROW_WORDS;
	assign first_word  = WBW'(static_q);
	assign scan_row    = RBW'(ROWS - 1) - scan_q;

	// addresses
	assign base_addr = AW'(row_q) * AW'(ROW_WORDS);
	assign cur_addr  = base_addr + AW'(word_q);
	assign prev_addr = base_addr + AW'(word_q - WBW'(1));
	assign scan_addr = AW'(scan_row) * AW'(ROW_WORDS) + AW'(word_q);
	assign in_addr   = AW'(wr_row) * AW'(ROW_WORDS) + AW'(wr_word);
	assign in_ok     = (int'(wr_row) < ROWS) && (int'(wr_word) < ROW_WORDS);

	// memory port selection
	always_comb begin
		mem_we = cmd.clr_wr | (cmd.in_wr & in_ok) | cmd.rot_wr | cmd.rot_last;
		mem_re = cmd.scan_rd | cmd.rot_rd;
		mem_ra = cmd.scan_rd ? scan_addr : cur_addr;
		if (cmd.clr_wr) begin
			mem_wa = cur_addr;
			mem_wd = '0;
		end else if (cmd.in_wr) begin
			mem_wa = in_addr;
			mem_wd = wr_data;
		end else if (cmd.rot_wr) begin
			mem_wa = prev_addr;
			mem_wd = {prev_q[DATA_W-2:0], rd_data_q[DATA_W-1]};
		end else begin
			mem_wa = cur_addr;
			mem_wd = {prev_q[DATA_W-2:0], carry_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_data_q <= mem[mem_ra];
	end

	// row and word counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			word_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				if (word_q == WBW'(ROW_WORDS - 1)) begin
					word_q <= '0;
					row_q  <= row_q + RBW'(1);
				end else begin
					word_q <= word_q + WBW'(1);
				end
			end
			if (cmd.start) word_q <= '0;
			if (cmd.scan_ld) begin
				if (sts.shown_last) begin
					word_q <= first_word;
					row_q  <= '0;
				end else begin
					word_q <= word_q + WBW'(1);
				end
			end
			if ((cmd.rot_first || cmd.rot_wr) && !sts.word_end) word_q <= word_q + WBW'(1);
			if (cmd.rot_last) begin
				word_q <= first_word;
				row_q  <= row_q + RBW'(1);
			end
		end
	end

	// rotation word carry
	always_ff @(posedge clk) begin
		if (cmd.rot_first || cmd.rot_wr) prev_q <= rd_data_q;
		if (cmd.rot_first) carry_q <= rd_data_q[DATA_W-1];
	end

	// scan position and frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.scan_ld && sts.shown_last) begin
			scan_q <= frame_wrap ? '0 : scan_q + RBW'(1);
			if (frame_wrap && scroll_on_q) cnt_q <= (cnt_next == period) ? '0 : cnt_next;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.scan_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_ld) begin
			row_drive_q <= ~(DATA_W'(1) << scan_q);
			col_data_q  <= rd_data_q;
			last_q      <= sts.shown_last;
		end
	end

	assign out_valid = out_valid_q;
	assign row_drive = row_drive_q;
	assign col_data  = col_data_q;
	assign last_word = last_q;

	// status
	always_comb begin
		sts.clr_done   = (row_q == RBW'(ROWS - 1)) && (word_q == WBW'(ROW_WORDS - 1));
		sts.shown_last = word_q == WBW'(SHOWN_N - 1);
		sts.word_end   = word_q == WBW'(ROW_WORDS - 1);
		sts.row_end    = row_q == RBW'(ROWS - 1);
		sts.out_free   = !out_valid_q || out_ready;
		sts.rotate_due = frame_wrap && scroll_on_q && (cnt_next == period) && static_fits;
	end

	// an output word is never loaded over one still waiting
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_ld |-> (!out_valid_q || out_ready))
		else $error("output word overwritten while stalled");

	// one writer and one reader of the frame store at a time
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.in_wr, cmd.rot_wr, cmd.rot_last})
		&& $onehot0({cmd.scan_rd, cmd.rot_rd}))
		else $error("frame store port conflict");

	// the row advances once the last word of a scan is loaded
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_ld && sts.shown_last) |=> (scan_q != $past(scan_q)))
		else $error("scan position did not advance");

	// the frame counter moves only at the end of a row scan
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan_ld && sts.shown_last) |=> $stable(cnt_q))
		else $error("frame counter changed outside a frame end");

endmodule
